/* sv/bfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;
   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_RESERVE = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_MARKALL = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] free_address;
      logic [15:0] range_start;
      logic [15:0] range_end;
   } req_type;

   typedef struct packed {
      logic        alloc_ok;
      logic [26:0] alloc_address;
      logic [15:0] used_frames;
      logic [15:0] free_frames;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_SET, OP_CLEAR, OP_ALLOC
   } op_type;

   typedef struct packed {
      logic   load;
      logic   step;
      op_type op;
      logic   set_count;
      logic   finish;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic hit;
   } sts_type;
endpackage
`default_nettype wire

/* sv/bfa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bfa_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [2:0]     action,
   input  wire bfa_pkg::sts_type sts,
   output logic                busy,
   output bfa_pkg::cmd_type    cmd
);
   typedef enum logic [1:0] {S_IDLE, S_INIT, S_WALK, S_DONE} state_type;
   state_type state_ff;
   bfa_pkg::op_type op_ff;
   logic markall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         op_ff <= bfa_pkg::OP_NONE;
         markall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               if (sts.last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_WALK;
                  markall_ff <= (action == bfa_pkg::ACT_MARKALL);
                  unique case (action)
                     bfa_pkg::ACT_ALLOC: op_ff <= bfa_pkg::OP_ALLOC;
                     bfa_pkg::ACT_FREE, bfa_pkg::ACT_RELEASE: op_ff <= bfa_pkg::OP_CLEAR;
                     bfa_pkg::ACT_RESERVE, bfa_pkg::ACT_MARKALL: op_ff <= bfa_pkg::OP_SET;
                     default: op_ff <= bfa_pkg::OP_NONE;
                  endcase
               end
            end
            S_WALK: begin
               if (sts.last || (op_ff == bfa_pkg::OP_ALLOC && sts.hit)) state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
      cmd.load = (state_ff == S_IDLE) && start;
      cmd.step = (state_ff == S_WALK) || (state_ff == S_INIT);
      cmd.op = (state_ff == S_INIT) ? bfa_pkg::OP_SET : op_ff;
      cmd.set_count = (state_ff == S_INIT) || ((state_ff == S_WALK) && markall_ff);
      cmd.finish = (state_ff == S_DONE);
   end
endmodule
`default_nettype wire

/* sv/bfa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bfa_datapath #(
   parameter int MAX_FRAMES = 32768,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bfa_pkg::req_type req,
   input  wire logic [15:0]      frames_present,
   input  wire bfa_pkg::cmd_type cmd,
   output bfa_pkg::sts_type      sts,
   output logic                  rsp_valid,
   output bfa_pkg::rsp_type      rsp
);
   localparam int FW = $clog2(MAX_FRAMES);
   localparam int CW = (FW + 1 > 17) ? FW + 1 : 17;

   logic mem [MAX_FRAMES];
   logic [CW-1:0] cur_ff, stop_ff;
   logic [15:0]   used_ff;
   logic          ok_ff, rd_ff;
   logic [CW-1:0] n_w, cur_in, first_w, last_w, fa_w;
   logic          addr_ok;
   logic [CW-1:0] prev_ff;
   logic          prevv_ff;

   always_comb begin
      n_w = ({{(CW-16){1'b0}}, frames_present} < CW'(MAX_FRAMES))
            ? {{(CW-16){1'b0}}, frames_present} : CW'(MAX_FRAMES);
      fa_w = CW'(req.free_address >> PAGE_SHIFT);
      addr_ok = (req.free_address != 32'd0) &&
                (req.free_address[PAGE_SHIFT-1:0] == '0) &&
                ((req.free_address >> PAGE_SHIFT) < 32'(MAX_FRAMES));
      first_w = '0;
      last_w = '0;
      unique case (req.action)
         bfa_pkg::ACT_ALLOC: begin first_w = CW'(1); last_w = n_w; end
         bfa_pkg::ACT_FREE: begin
            if (addr_ok) begin first_w = fa_w; last_w = fa_w + CW'(1); end
         end
         bfa_pkg::ACT_RESERVE, bfa_pkg::ACT_RELEASE: begin
            first_w = {{(CW-16){1'b0}}, req.range_start};
            last_w = {{(CW-16){1'b0}}, req.range_end};
         end
         bfa_pkg::ACT_MARKALL: begin first_w = '0; last_w = n_w; end
         default: ;
      endcase
      if (last_w > n_w) last_w = n_w;
      cur_in = cur_ff + CW'(1);
   end

   // A frame is read, then updated in the next cycle; prev_ff holds it.
   logic in_rng;
   assign in_rng = prevv_ff;
   assign sts.hit = in_rng && !rd_ff && cmd.op == bfa_pkg::OP_ALLOC;
   assign sts.last = !(cur_ff < stop_ff) && !in_rng;

   always_ff @(posedge clock) begin
      rd_ff <= mem[cur_ff[FW-1:0]];
      if (cmd.step && in_rng && (cmd.op == bfa_pkg::OP_SET ||
          cmd.op == bfa_pkg::OP_CLEAR || (cmd.op == bfa_pkg::OP_ALLOC && !rd_ff)))
         mem[prev_ff[FW-1:0]] <= (cmd.op != bfa_pkg::OP_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         stop_ff <= CW'(MAX_FRAMES);
         used_ff <= '0;
         prevv_ff <= 1'b0;
         prev_ff <= '0;
         ok_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.load) begin
            cur_ff <= first_w;
            stop_ff <= last_w;
            prevv_ff <= 1'b0;
            ok_ff <= 1'b0;
            if (req.action == bfa_pkg::ACT_MARKALL) used_ff <= n_w[15:0];
         end else if (cmd.step) begin
            if (sts.hit) begin
               ok_ff <= 1'b1;
               prevv_ff <= 1'b0;
               stop_ff <= cur_ff;
               if (used_ff != 16'hFFFF) used_ff <= used_ff + 16'd1;
            end else begin
               prevv_ff <= (cur_ff < stop_ff);
               prev_ff <= cur_ff;
               if (cur_ff < stop_ff) cur_ff <= cur_in;
               if (in_rng && !cmd.set_count) begin
                  if (cmd.op == bfa_pkg::OP_SET && !rd_ff && used_ff != 16'hFFFF)
                     used_ff <= used_ff + 16'd1;
                  else if (cmd.op == bfa_pkg::OP_CLEAR && rd_ff && used_ff != 16'd0)
                     used_ff <= used_ff - 16'd1;
               end
            end
            if (cmd.set_count && sts.last) begin
               cur_ff <= '0;
               stop_ff <= '0;
            end
         end
         if (cmd.finish) begin
            rsp.alloc_ok <= ok_ff;
            rsp.alloc_address <= ok_ff ? 27'(27'(prev_ff) << PAGE_SHIFT) : 27'd0;
            rsp.used_frames <= used_ff;
            rsp.free_frames <= (n_w > {{(CW-16){1'b0}}, used_ff})
                               ? 16'(n_w - {{(CW-16){1'b0}}, used_ff}) : 16'd0;
         end
      end
   end
endmodule
`default_nettype wire

/* sv/bitmap_frame_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bitmap page-frame allocator with first-fit allocation.
// A command is taken when start is high and busy is low; req carries the
// action and its operands. One response per command appears on rsp for one
// cycle, marked by rsp_valid; the receiver cannot stall it.
// The frame bitmap sits in a memory that is read at one frame while the frame
// before is written, walked one frame per cycle. A command visits the range
// length for range actions, the frame count for mark-all, the frames up to
// the first free one for allocation, and one frame for free.
// The csr_we / csr_wdata port writes the frame count; write it only while
// idle. After reset the block walks the whole bitmap setting every bit,
// with busy high; the used count starts at zero.
module bitmap_frame_allocator_unit #(
   parameter int MAX_FRAMES = 32768,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bfa_pkg::req_type req_item,
   output logic                  rsp_valid,
   output bfa_pkg::rsp_type      rsp_item,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_wdata
);
   logic [15:0] frames_ff;
   bfa_pkg::cmd_type cmd;
   bfa_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) frames_ff <= '0;
      else if (csr_we) frames_ff <= csr_wdata;
   end

   bfa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .action(req_item.action),
      .sts(sts), .busy(busy), .cmd(cmd)
   );

   bfa_datapath #(.MAX_FRAMES(MAX_FRAMES), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
      .clock(clock), .reset(reset), .req(req_item), .frames_present(frames_ff),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid), .rsp(rsp_item)
   );

   a_ok_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.alloc_ok |-> rsp_item.alloc_address == 27'd0)
      else $error("address without allocation");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("double response");
endmodule
`default_nettype wire
